>>> hw/rtl/tafs_pkg.sv
// Shared types and constants for the triangle angle pipeline.
// No dependencies; used by tafs_prod, tafs_lane and triangle_angles_from_sides.
package tafs_pkg;

    typedef struct packed {
        logic [7:0] deg;
        logic [5:0] mins;
        logic [5:0] secs;
    } t_dms;

    localparam int N_PROD = 6;
    localparam int P_AA   = 0;
    localparam int P_BB   = 1;
    localparam int P_CC   = 2;
    localparam int P_AB   = 3;
    localparam int P_BC   = 4;
    localparam int P_CA   = 5;

    localparam int N_LANE   = 3;
    localparam int PROD_LAT = 2;
    localparam int LANE_LAT = 99;
    localparam int PIPE_LAT = PROD_LAT + LANE_LAT;

endpackage

>>> hw/rtl/tafs_prod.sv
// Shared squares and cross products of the three sides, two stages.
// Partial products of 32x32 bits, then a summing stage. Uses tafs_pkg.
module tafs_prod #(
    parameter int SIDE_WIDTH = 48
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [SIDE_WIDTH-1:0]     i_a,
    input  logic [SIDE_WIDTH-1:0]     i_b,
    input  logic [SIDE_WIDTH-1:0]     i_c,
    output logic [2*SIDE_WIDTH-1:0]   o_prod [tafs_pkg::N_PROD]
);
    import tafs_pkg::*;

    localparam int PW = 2 * SIDE_WIDTH;

    logic [63:0]  w_x [N_PROD];
    logic [63:0]  w_y [N_PROD];
    logic [63:0]  r_ll [N_PROD];
    logic [63:0]  r_lh [N_PROD];
    logic [63:0]  r_hl [N_PROD];
    logic [63:0]  r_hh [N_PROD];
    logic [127:0] w_sum [N_PROD];
    logic [PW-1:0] r_prod [N_PROD];

    always_comb begin
        w_x[P_AA] = 64'(i_a); w_y[P_AA] = 64'(i_a);
        w_x[P_BB] = 64'(i_b); w_y[P_BB] = 64'(i_b);
        w_x[P_CC] = 64'(i_c); w_y[P_CC] = 64'(i_c);
        w_x[P_AB] = 64'(i_a); w_y[P_AB] = 64'(i_b);
        w_x[P_BC] = 64'(i_b); w_y[P_BC] = 64'(i_c);
        w_x[P_CA] = 64'(i_c); w_y[P_CA] = 64'(i_a);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N_PROD; k++) begin
                r_ll[k] <= 64'(w_x[k][31:0]) * 64'(w_y[k][31:0]);
                r_lh[k] <= 64'(w_x[k][31:0]) * 64'(w_y[k][63:32]);
                r_hl[k] <= 64'(w_x[k][63:32]) * 64'(w_y[k][31:0]);
                r_hh[k] <= 64'(w_x[k][63:32]) * 64'(w_y[k][63:32]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < N_PROD; k++) begin
            w_sum[k] = 128'(r_ll[k]) + ((128'(r_lh[k]) + 128'(r_hl[k])) << 32)
                     + (128'(r_hh[k]) << 64);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N_PROD; k++) begin
                r_prod[k] <= w_sum[k][PW-1:0];
            end
        end
    end

    assign o_prod = r_prod;

endmodule

>>> hw/rtl/tafs_lane.sv
// One angle lane: cosine divider, sine square root, CORDIC arccos, degree split.
// Fully pipelined, one stage per step. Uses tafs_pkg (t_dms).
module tafs_lane #(
    parameter int SIDE_WIDTH = 48
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [2*SIDE_WIDTH-1:0]   i_pp,
    input  logic [2*SIDE_WIDTH-1:0]   i_qq,
    input  logic [2*SIDE_WIDTH-1:0]   i_ss,
    input  logic [2*SIDE_WIDTH-1:0]   i_pq,
    output tafs_pkg::t_dms            o_dms
);
    import tafs_pkg::*;

    localparam int PW       = 2 * SIDE_WIDTH;
    localparam int NW       = PW + 1;
    localparam int RW       = PW + 2;
    localparam int DIV_N    = 30;
    localparam int SQRT_N   = 31;
    localparam int CORDIC_N = 30;
    localparam int XW       = 34;
    localparam int VW       = 61;
    localparam int SW       = 62;

    localparam logic signed [XW-1:0] PI_Q30  = 34'sd3373259426;
    localparam logic [31:0]          K_DEG   = 32'd3845054675;
    localparam logic [30:0]          ONE_Q30 = 31'h4000_0000;
    localparam logic [SW-1:0]        ONE_SQ  = 62'd1 << 60;
    localparam logic [31:0] ATAN_TAB [CORDIC_N] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2
    };

    // numerator and denominator
    logic [NW-1:0] r_sum, r_ss, r_den1, r_num, r_den2;
    logic          r_neg2;
    logic          w_neg;
    logic [NW-1:0] w_num;

    // restoring divider
    logic [RW-1:0]    r_rem  [DIV_N+1];
    logic [NW-1:0]    r_dd   [DIV_N+1];
    logic [DIV_N-1:0] r_q    [DIV_N+1];
    logic             r_dsat [DIV_N+1];
    logic             r_dneg [DIV_N+1];
    logic [RW-1:0]    w_sh   [DIV_N+1];
    logic             w_ge   [DIV_N+1];

    // square root
    logic [30:0]   w_c;
    logic [SW-1:0] w_c2;
    logic [VW-1:0] r_sv   [SQRT_N+1];
    logic [SW-1:0] r_sr   [SQRT_N+1];
    logic [30:0]   r_sc   [SQRT_N+1];
    logic          r_sneg [SQRT_N+1];
    logic [SW-1:0] w_bit  [SQRT_N+1];
    logic [SW-1:0] w_t    [SQRT_N+1];
    logic          w_fit  [SQRT_N+1];

    // CORDIC
    logic signed [XW-1:0] r_x [CORDIC_N];
    logic signed [XW-1:0] r_y [CORDIC_N];
    logic signed [XW-1:0] r_z [CORDIC_N];
    logic                 r_cneg [CORDIC_N];
    logic signed [XW-1:0] w_xi [CORDIC_N];
    logic signed [XW-1:0] w_yi [CORDIC_N];
    logic signed [XW-1:0] w_zi [CORDIC_N];
    logic                 w_ni [CORDIC_N];

    // degrees, minutes, seconds
    logic signed [XW-1:0] w_a;
    logic [31:0]          w_ang;
    logic [31:0]          r_ang;
    logic [63:0]          r_d;
    logic [SW-1:0]        w_f;
    logic [7:0]           r_deg;
    logic [5:0]           r_min;
    logic [55:0]          r_fr;
    logic [SW-1:0]        w_g;
    t_dms                 r_dms;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= NW'(i_pp) + NW'(i_qq);
            r_ss   <= NW'(i_ss);
            r_den1 <= {i_pq, 1'b0};
        end
    end

    always_comb begin
        w_neg = r_sum < r_ss;
        w_num = w_neg ? (r_ss - r_sum) : (r_sum - r_ss);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= w_num;
            r_den2 <= r_den1;
            r_neg2 <= w_neg;
        end
    end

    always_comb begin
        w_sh[0] = '0;
        w_ge[0] = 1'b0;
        for (int k = 1; k <= DIV_N; k++) begin
            w_sh[k] = {r_rem[k-1][RW-2:0], 1'b0};
            w_ge[k] = w_sh[k] >= RW'(r_dd[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= RW'(r_num);
            r_dd[0]   <= r_den2;
            r_q[0]    <= '0;
            r_dsat[0] <= r_num >= r_den2;
            r_dneg[0] <= r_neg2;
            for (int k = 1; k <= DIV_N; k++) begin
                r_rem[k]  <= w_ge[k] ? (w_sh[k] - RW'(r_dd[k-1])) : w_sh[k];
                r_dd[k]   <= r_dd[k-1];
                r_q[k]    <= {r_q[k-1][DIV_N-2:0], w_ge[k]};
                r_dsat[k] <= r_dsat[k-1];
                r_dneg[k] <= r_dneg[k-1];
            end
        end
    end

    always_comb begin
        w_c  = r_dsat[DIV_N] ? ONE_Q30 : {1'b0, r_q[DIV_N]};
        w_c2 = SW'(w_c) * SW'(w_c);
        w_bit[0] = '0;
        w_t[0]   = '0;
        w_fit[0] = 1'b0;
        for (int k = 1; k <= SQRT_N; k++) begin
            w_bit[k] = ONE_SQ >> (2 * (k - 1));
            w_t[k]   = r_sr[k-1] + w_bit[k];
            w_fit[k] = SW'(r_sv[k-1]) >= w_t[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sv[0]   <= VW'(ONE_SQ - w_c2);
            r_sr[0]   <= '0;
            r_sc[0]   <= w_c;
            r_sneg[0] <= r_dneg[DIV_N];
            for (int k = 1; k <= SQRT_N; k++) begin
                r_sv[k]   <= w_fit[k] ? VW'(SW'(r_sv[k-1]) - w_t[k]) : r_sv[k-1];
                r_sr[k]   <= w_fit[k] ? ((r_sr[k-1] >> 1) + w_bit[k]) : (r_sr[k-1] >> 1);
                r_sc[k]   <= r_sc[k-1];
                r_sneg[k] <= r_sneg[k-1];
            end
        end
    end

    always_comb begin
        w_xi[0] = $signed(XW'(r_sc[SQRT_N]));
        w_yi[0] = $signed(XW'(r_sr[SQRT_N]));
        w_zi[0] = '0;
        w_ni[0] = r_sneg[SQRT_N];
        for (int i = 1; i < CORDIC_N; i++) begin
            w_xi[i] = r_x[i-1];
            w_yi[i] = r_y[i-1];
            w_zi[i] = r_z[i-1];
            w_ni[i] = r_cneg[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < CORDIC_N; i++) begin
                if (w_yi[i] >= 0) begin
                    r_x[i] <= w_xi[i] + (w_yi[i] >>> i);
                    r_y[i] <= w_yi[i] - (w_xi[i] >>> i);
                    r_z[i] <= w_zi[i] + $signed({2'b00, ATAN_TAB[i]});
                end else begin
                    r_x[i] <= w_xi[i] - (w_yi[i] >>> i);
                    r_y[i] <= w_yi[i] + (w_xi[i] >>> i);
                    r_z[i] <= w_zi[i] - $signed({2'b00, ATAN_TAB[i]});
                end
                r_cneg[i] <= w_ni[i];
            end
        end
    end

    always_comb begin
        w_a = r_cneg[CORDIC_N-1] ? (PI_Q30 - r_z[CORDIC_N-1]) : r_z[CORDIC_N-1];
        if (w_a < 0) begin
            w_ang = '0;
        end else if (w_a > PI_Q30 - 34'sd1) begin
            w_ang = 32'(PI_Q30 - 34'sd1);
        end else begin
            w_ang = 32'(w_a);
        end
    end

    // x*60 as (x << 6) - (x << 2)
    always_comb begin
        w_f = {r_d[55:0], 6'b0} - {4'b0, r_d[55:0], 2'b0};
        w_g = {r_fr, 6'b0} - {4'b0, r_fr, 2'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang      <= w_ang;
            r_d        <= 64'(r_ang) * 64'(K_DEG);
            r_deg      <= r_d[63:56];
            r_min      <= w_f[61:56];
            r_fr       <= w_f[55:0];
            r_dms.deg  <= r_deg;
            r_dms.mins <= r_min;
            r_dms.secs <= w_g[61:56];
        end
    end

    assign o_dms = r_dms;

endmodule

>>> hw/rtl/triangle_angles_from_sides.sv
// Path from input beat to output beat: 2 product stages, 99 lane stages,
// output register. Throughput: one beat per cycle while o_stall is low.
// The three lanes run side by side, each a fixed-depth pipeline; a skid stage
// at the output lets one more beat in while a result is stalled.
// Reset (synchronous, active low) clears the valid line, output and skid flags.
module triangle_angles_from_sides #(
    parameter int SIDE_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SIDE_WIDTH-1:0] i_len_a,
    input  logic [SIDE_WIDTH-1:0] i_len_b,
    input  logic [SIDE_WIDTH-1:0] i_len_c,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_valid_res,
    output logic [7:0]            o_deg_opp_c,
    output logic [5:0]            o_min_opp_c,
    output logic [5:0]            o_sec_opp_c,
    output logic [7:0]            o_deg_opp_a,
    output logic [5:0]            o_min_opp_a,
    output logic [5:0]            o_sec_opp_a,
    output logic [7:0]            o_deg_opp_b,
    output logic [5:0]            o_min_opp_b,
    output logic [5:0]            o_sec_opp_b
);
    import tafs_pkg::*;

    localparam int PW = 2 * SIDE_WIDTH;
    localparam int LAST = PIPE_LAT - 1;

    logic                  w_en;
    logic                  w_ok;
    logic [SIDE_WIDTH:0]   w_bc, w_ca, w_ab;
    logic [PIPE_LAT-1:0]   r_vl;
    logic [PIPE_LAT-1:0]   r_okl;
    logic [PW-1:0]         w_prod [N_PROD];
    t_dms                  w_lane [N_LANE];
    t_dms                  w_dms  [N_LANE];
    logic                  r_ov, r_sv;
    logic                  r_o_res, r_s_res;
    t_dms                  r_o_dms [N_LANE];
    t_dms                  r_s_dms [N_LANE];

    assign w_en    = !r_sv;
    assign o_stall = r_sv;

    always_comb begin
        w_bc = {1'b0, i_len_b} + {1'b0, i_len_c};
        w_ca = {1'b0, i_len_c} + {1'b0, i_len_a};
        w_ab = {1'b0, i_len_a} + {1'b0, i_len_b};
        w_ok = (i_len_a != '0) && (i_len_b != '0) && (i_len_c != '0)
            && ({1'b0, i_len_a} < w_bc) && ({1'b0, i_len_b} < w_ca)
            && ({1'b0, i_len_c} < w_ab);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl <= '0;
        end else if (w_en) begin
            r_vl <= {r_vl[PIPE_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_okl <= {r_okl[PIPE_LAT-2:0], w_ok};
        end
    end

    tafs_prod #(.SIDE_WIDTH(SIDE_WIDTH)) u_prod (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (i_len_a),
        .i_b    (i_len_b),
        .i_c    (i_len_c),
        .o_prod (w_prod)
    );

    tafs_lane #(.SIDE_WIDTH(SIDE_WIDTH)) u_lane_c (
        .i_clk (i_clk), .i_en (w_en),
        .i_pp (w_prod[P_AA]), .i_qq (w_prod[P_BB]), .i_ss (w_prod[P_CC]),
        .i_pq (w_prod[P_AB]), .o_dms (w_lane[0])
    );

    tafs_lane #(.SIDE_WIDTH(SIDE_WIDTH)) u_lane_a (
        .i_clk (i_clk), .i_en (w_en),
        .i_pp (w_prod[P_BB]), .i_qq (w_prod[P_CC]), .i_ss (w_prod[P_AA]),
        .i_pq (w_prod[P_BC]), .o_dms (w_lane[1])
    );

    tafs_lane #(.SIDE_WIDTH(SIDE_WIDTH)) u_lane_b (
        .i_clk (i_clk), .i_en (w_en),
        .i_pp (w_prod[P_CC]), .i_qq (w_prod[P_AA]), .i_ss (w_prod[P_BB]),
        .i_pq (w_prod[P_CA]), .o_dms (w_lane[2])
    );

    // invalid triangles give all-zero angles
    always_comb begin
        for (int k = 0; k < N_LANE; k++) begin
            w_dms[k] = r_okl[LAST] ? w_lane[k] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (!i_stall) begin
                r_sv <= 1'b0;
            end
        end else if (r_vl[LAST]) begin
            if (r_ov && i_stall) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (!i_stall) begin
                r_o_res <= r_s_res;
                r_o_dms <= r_s_dms;
            end
        end else if (r_vl[LAST]) begin
            if (r_ov && i_stall) begin
                r_s_res <= r_okl[LAST];
                r_s_dms <= w_dms;
            end else begin
                r_o_res <= r_okl[LAST];
                r_o_dms <= w_dms;
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_valid_res = r_o_res;
    assign o_deg_opp_c = r_o_dms[0].deg;
    assign o_min_opp_c = r_o_dms[0].mins;
    assign o_sec_opp_c = r_o_dms[0].secs;
    assign o_deg_opp_a = r_o_dms[1].deg;
    assign o_min_opp_a = r_o_dms[1].mins;
    assign o_sec_opp_a = r_o_dms[1].secs;
    assign o_deg_opp_b = r_o_dms[2].deg;
    assign o_min_opp_b = r_o_dms[2].mins;
    assign o_sec_opp_b = r_o_dms[2].secs;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a beat while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && i_stall && r_vl[LAST]))
        else $error("skid filled without a stalled output");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_deg_opp_c == 8'd0 && o_min_opp_c == 6'd0
            && o_sec_opp_c == 6'd0 && o_deg_opp_a == 8'd0 && o_min_opp_a == 6'd0
            && o_sec_opp_a == 6'd0 && o_deg_opp_b == 8'd0 && o_min_opp_b == 6'd0
            && o_sec_opp_b == 6'd0))
        else $error("invalid triangle with nonzero angle");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |=> $stable(r_vl))
        else $error("pipeline moved while skid was full");
`endif

endmodule
